/* sv/mexp_pkg.sv */
`timescale 1ns / 1ps

package mexp_pkg;

	localparam logic [29:0] MODULUS = 30'd1000000007;

	// Barrett factor floor(2^60 / MODULUS)
	localparam logic [63:0] MU_WIDE = (64'd1 << 60) / {34'd0, MODULUS};
	localparam logic [30:0] MU      = MU_WIDE[30:0];

	typedef struct packed {
		logic        go;
		logic        reduce;
		logic [29:0] a;
		logic [29:0] b;
		logic [30:0] x;
	} mm_req_t;

	typedef struct packed {
		logic        done;
		logic [29:0] value;
	} mm_rsp_t;

endpackage

/* sv/mexp_mulmod.sv */
`timescale 1ns / 1ps

module mexp_mulmod import mexp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output mm_rsp_t rsp
);

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_Q1   = 3'd1;
	localparam logic [2:0] M_Q2   = 3'd2;
	localparam logic [2:0] M_SUB  = 3'd3;
	localparam logic [2:0] M_FIX  = 3'd4;

	logic [2:0]  state_q;
	logic [63:0] m_q;
	logic [59:0] p_q;
	logic [31:0] r_q;
	logic [31:0] mult_x;
	logic [31:0] mult_y;
	logic [63:0] m_d;
	logic        r_ge;

	always_comb begin
		case (state_q)
			M_IDLE: begin
				mult_x = {2'b00, req.a};
				mult_y = {2'b00, req.b};
			end
			M_Q1: begin
				mult_x = {1'b0, m_q[59:29]};
				mult_y = {1'b0, MU};
			end
			M_Q2: begin
				mult_x = {1'b0, m_q[61:31]};
				mult_y = {2'b00, MODULUS};
			end
			default: begin
				mult_x = 32'd0;
				mult_y = 32'd0;
			end
		endcase
	end

	assign m_d  = {32'd0, mult_x} * {32'd0, mult_y};
	assign r_ge = r_q >= {2'b00, MODULUS};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (req.go) begin
						state_q <= req.reduce ? M_FIX : M_Q1;
					end
				end
				M_Q1:  state_q <= M_Q2;
				M_Q2:  state_q <= M_SUB;
				M_SUB: state_q <= M_FIX;
				M_FIX: begin
					if (!r_ge) begin
						state_q <= M_IDLE;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (req.go) begin
					m_q <= m_d;
					r_q <= {1'b0, req.x};
				end
			end
			M_Q1: begin
				p_q <= m_q[59:0];
				m_q <= m_d;
			end
			M_Q2: begin
				m_q <= m_d;
			end
			M_SUB: begin
				r_q <= p_q[31:0] - m_q[31:0];
			end
			M_FIX: begin
				if (r_ge) begin
					r_q <= r_q - {2'b00, MODULUS};
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.done  = (state_q == M_FIX) && !r_ge;
	assign rsp.value = r_q[29:0];

endmodule

/* sv/modular_exponentiation_unit.sv */
`timescale 1ns / 1ps

// Modular exponentiation, base_value ** exponent mod 1000000007.
// Command channel: a beat is taken at the clock edge where start is high
// and busy is low; base_value and exponent are sampled at that edge only.
// busy stays high until the result has been shown.
// Result channel: done is high for exactly one cycle with power_mod valid;
// the receiver cannot stall it, so the beat must be taken in that cycle.
// A zero or negative exponent gives 1.
// One modular product runs on the single shared 32x32 multiplier in
// steps: product, Barrett quotient estimate, quotient times modulus,
// subtract, up to two correcting subtracts. One item is in flight at
// a time; the next beat is taken the cycle after done.
// Reset clears the sequencer and drops any item in flight.

module modular_exponentiation_unit import mexp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [30:0] base_value,
	input  logic signed [31:0] exponent,
	output logic        done,
	output logic [29:0] power_mod
);

	localparam logic [2:0] T_IDLE = 3'd0;
	localparam logic [2:0] T_RED  = 3'd1;
	localparam logic [2:0] T_BIT  = 3'd2;
	localparam logic [2:0] T_MULW = 3'd3;
	localparam logic [2:0] T_SQW  = 3'd4;
	localparam logic [2:0] T_OUT  = 3'd5;

	logic [2:0]  state_q;
	logic [30:0] e_q;
	logic [29:0] base_q;
	logic [29:0] result_q;
	logic        accept;
	mm_req_t     req;
	mm_rsp_t     rsp;

	assign busy   = state_q != T_IDLE;
	assign accept = start && !busy;

	always_comb begin
		req.go     = 1'b0;
		req.reduce = 1'b0;
		req.a      = e_q[0] ? result_q : base_q;
		req.b      = base_q;
		req.x      = base_value;
		case (state_q)
			T_IDLE: begin
				req.go     = start;
				req.reduce = 1'b1;
			end
			T_BIT: begin
				req.go = e_q != 31'd0;
			end
			default: begin
			end
		endcase
	end

	mexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						state_q <= T_RED;
					end
				end
				T_RED: begin
					if (rsp.done) begin
						state_q <= T_BIT;
					end
				end
				T_BIT: begin
					if (e_q == 31'd0) begin
						state_q <= T_OUT;
					end else begin
						state_q <= e_q[0] ? T_MULW : T_SQW;
					end
				end
				T_MULW, T_SQW: begin
					if (rsp.done) begin
						state_q <= T_BIT;
					end
				end
				T_OUT:   state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: begin
				if (accept) begin
					e_q      <= exponent[31] ? 31'd0 : exponent[30:0];
					result_q <= 30'd1;
				end
			end
			T_RED: begin
				if (rsp.done) begin
					base_q <= rsp.value;
				end
			end
			T_MULW: begin
				// drop the consumed bit; the square follows from T_BIT unless no bits remain
				if (rsp.done) begin
					result_q <= rsp.value;
					e_q[0]   <= 1'b0;
				end
			end
			T_SQW: begin
				if (rsp.done) begin
					base_q <= rsp.value;
					e_q    <= {1'b0, e_q[30:1]};
				end
			end
			default: begin
			end
		endcase
	end

	assign done      = state_q == T_OUT;
	assign power_mod = result_q;

endmodule
